>>> design/wasm_instruction_boundary_finder_defines.svh
// ----------------------------------------------------------------------------
// wasm instruction boundary finder assertion macros
// concurrent checks that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef WASM_INSTRUCTION_BOUNDARY_FINDER_DEFINES_SVH
`define WASM_INSTRUCTION_BOUNDARY_FINDER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, quiet while reset is held
`define WIBF_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("wibf assertion failed");
// next-cycle implication, quiet while reset is held
`define WIBF_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("wibf assertion failed");
`else
`define WIBF_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define WIBF_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

>>> design/wibf_pkg.sv
// ----------------------------------------------------------------------------
// wibf_pkg
// opcodes, immediate decode steps and decode functions for the
// wasm instruction boundary finder
// ----------------------------------------------------------------------------
package wibf_pkg;

  // length counter width and its saturation value
  localparam int LENGTH_BITS = 16;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  typedef logic [LENGTH_BITS-1:0] len_t;
  typedef logic [2:0]             step_t;

  // immediate decode steps
  localparam step_t STEP_NONE     = 3'd0;
  localparam step_t STEP_RAW      = 3'd1;
  localparam step_t STEP_SUB      = 3'd2;
  localparam step_t STEP_LEB_LAST = 3'd3;
  localparam step_t STEP_LEB_TWO  = 3'd4;
  localparam step_t STEP_ALIGN    = 3'd5;
  localparam step_t STEP_COUNT    = 3'd6;
  localparam step_t STEP_TARGETS  = 3'd7;

  // leb bytes that still add to the value
  localparam logic [2:0] LEB_MAX_BYTES = 3'd5;

  // raw constant sizes
  localparam logic [3:0] F32_BYTES = 4'd4;
  localparam logic [3:0] F64_BYTES = 4'd8;

  // primary opcodes
  localparam logic [7:0] OP_BLOCK         = 8'h02;
  localparam logic [7:0] OP_LOOP          = 8'h03;
  localparam logic [7:0] OP_IF            = 8'h04;
  localparam logic [7:0] OP_BR            = 8'h0c;
  localparam logic [7:0] OP_BR_IF         = 8'h0d;
  localparam logic [7:0] OP_BRANCH_TABLE  = 8'h0e;
  localparam logic [7:0] OP_CALL          = 8'h10;
  localparam logic [7:0] OP_CALL_INDIRECT = 8'h11;
  localparam logic [7:0] OP_SELECT_T      = 8'h1c;
  localparam logic [7:0] OP_LOCAL_GET     = 8'h20;
  localparam logic [7:0] OP_LOCAL_SET     = 8'h21;
  localparam logic [7:0] OP_LOCAL_TEE     = 8'h22;
  localparam logic [7:0] OP_GLOBAL_GET    = 8'h23;
  localparam logic [7:0] OP_GLOBAL_SET    = 8'h24;
  localparam logic [7:0] OP_MEM_FIRST     = 8'h28;
  localparam logic [7:0] OP_MEM_LAST      = 8'h3e;
  localparam logic [7:0] OP_MEMORY_SIZE   = 8'h3f;
  localparam logic [7:0] OP_MEMORY_GROW   = 8'h40;
  localparam logic [7:0] OP_I32_CONST     = 8'h41;
  localparam logic [7:0] OP_I64_CONST     = 8'h42;
  localparam logic [7:0] OP_F32_CONST     = 8'h43;
  localparam logic [7:0] OP_F64_CONST     = 8'h44;
  localparam logic [7:0] OP_REF_NULL      = 8'hd0;
  localparam logic [7:0] OP_REF_FUNC      = 8'hd2;
  localparam logic [7:0] OP_PREFIX_FC     = 8'hfc;

  // sub-opcodes after the 0xfc prefix
  localparam logic [7:0] SUB_MEMORY_COPY = 8'h0a;
  localparam logic [7:0] SUB_MEMORY_FILL = 8'h0b;
  localparam logic [7:0] SUB_TABLE_COPY  = 8'h0e;
  localparam logic [7:0] SUB_TABLE_GROW  = 8'h0f;
  localparam logic [7:0] SUB_TABLE_SIZE  = 8'h10;
  localparam logic [7:0] SUB_TABLE_FILL  = 8'h11;

  // first immediate step for a primary opcode
  function automatic step_t step_for_opcode(logic [7:0] op);
    step_t step;
    if (op inside {[OP_MEM_FIRST:OP_MEM_LAST]}) begin
      step = STEP_ALIGN;
    end else if (op inside {OP_BLOCK, OP_LOOP, OP_IF, OP_BR, OP_BR_IF, OP_CALL,
                            OP_SELECT_T, OP_LOCAL_GET, OP_LOCAL_SET, OP_LOCAL_TEE,
                            OP_GLOBAL_GET, OP_GLOBAL_SET, OP_MEMORY_SIZE,
                            OP_MEMORY_GROW, OP_I32_CONST, OP_I64_CONST,
                            OP_REF_NULL, OP_REF_FUNC}) begin
      step = STEP_LEB_LAST;
    end else begin
      case (op)
        OP_CALL_INDIRECT: step = STEP_LEB_TWO;
        OP_F32_CONST:     step = STEP_RAW;
        OP_F64_CONST:     step = STEP_RAW;
        OP_BRANCH_TABLE:  step = STEP_COUNT;
        OP_PREFIX_FC:     step = STEP_SUB;
        default:          step = STEP_NONE;
      endcase
    end
    return step;
  endfunction

  // raw constant bytes for a primary opcode
  function automatic logic [3:0] raw_for_opcode(logic [7:0] op);
    logic [3:0] n;
    case (op)
      OP_F32_CONST: n = F32_BYTES;
      OP_F64_CONST: n = F64_BYTES;
      default:      n = 4'd0;
    endcase
    return n;
  endfunction

  // immediate step after a 0xfc sub-opcode
  function automatic step_t step_for_sub(logic [7:0] sub);
    step_t step;
    if (sub inside {SUB_MEMORY_COPY, SUB_TABLE_COPY}) begin
      step = STEP_LEB_TWO;
    end else if (sub inside {SUB_MEMORY_FILL, SUB_TABLE_GROW, SUB_TABLE_SIZE,
                             SUB_TABLE_FILL}) begin
      step = STEP_LEB_LAST;
    end else begin
      step = STEP_NONE;
    end
    return step;
  endfunction

endpackage

>>> design/wasm_instruction_boundary_finder.sv
// ----------------------------------------------------------------------------
// wasm_instruction_boundary_finder
// finds instruction boundaries in a webassembly code byte stream
// ----------------------------------------------------------------------------
// Usage:
//   in_* takes one code byte per item in in_tdata; in_tuser set marks the byte
//   as the opcode of a new instruction and drops any unfinished one.
//   out_* gives one item per finished instruction, on its final byte:
//   opcode, 0xfc sub-opcode (else 0) and length, plus a saturation flag.
//   Bytes that do not end an instruction give no item.
// Timing:
//   an item passes through an input register and the decode stage into the
//   output register, where its result is offered. One byte per cycle is
//   sustained while out_tready is high; the decode stage holds the
//   per-byte state (step, leb accumulator, branch target count, length).
// Reset and stalls:
//   rst_n low clears the decode state, so the next byte opens an instruction.
//   While out_tready is low and a result is held, the decode stage stops and
//   in_tready falls once the input register is full; nothing is lost.
// ----------------------------------------------------------------------------
`include "wasm_instruction_boundary_finder_defines.svh"

module wasm_instruction_boundary_finder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] code_byte
  input  logic        in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] opcode, [15:8] ext_opcode, [31:16] length
  output logic        out_tuser   // [0] length_saturated
);
  import wibf_pkg::*;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_restart_r;

  // decode state
  logic        in_instr_r,  in_instr_nxt;
  logic [7:0]  opcode_r,    opcode_nxt;
  logic [7:0]  ext_r,       ext_nxt;
  step_t       step_r,      step_nxt;
  logic [31:0] acc_r,       acc_nxt;
  logic [2:0]  idx_r,       idx_nxt;
  logic [3:0]  raw_r,       raw_nxt;
  logic [32:0] targets_r,   targets_nxt;
  len_t        count_r,     count_nxt;
  logic        ovf_r,       ovf_nxt;

  // output register
  logic        out_valid_r;
  logic [7:0]  out_opcode_r;
  logic [7:0]  out_ext_r;
  len_t        out_length_r;
  logic        out_sat_r;

  logic        advance;
  logic        fire;
  logic        start;
  logic [31:0] acc_new;
  logic [2:0]  idx_new;
  logic [3:0]  raw_dec;
  logic [32:0] targets_dec;

  // handshake: decode moves when the output register is free or draining
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign start     = s1_restart_r || !in_instr_r;

  // leb accumulation, seven bits per byte for four bytes, four bits from the fifth
  always_comb begin
    case (idx_r)
      3'd0:    acc_new = acc_r | {25'b0, s1_byte_r[6:0]};
      3'd1:    acc_new = acc_r | {18'b0, s1_byte_r[6:0], 7'b0};
      3'd2:    acc_new = acc_r | {11'b0, s1_byte_r[6:0], 14'b0};
      3'd3:    acc_new = acc_r | {4'b0, s1_byte_r[6:0], 21'b0};
      3'd4:    acc_new = acc_r | {s1_byte_r[3:0], 28'b0};
      default: acc_new = acc_r;
    endcase
    idx_new = (idx_r < LEB_MAX_BYTES) ? idx_r + 3'd1 : idx_r;
  end

  assign raw_dec     = raw_r - 4'd1;
  assign targets_dec = targets_r - 33'd1;

  // per-byte decode
  always_comb begin
    in_instr_nxt = in_instr_r;
    opcode_nxt   = opcode_r;
    ext_nxt      = ext_r;
    step_nxt     = step_r;
    acc_nxt      = acc_r;
    idx_nxt      = idx_r;
    raw_nxt      = raw_r;
    targets_nxt  = targets_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    fire         = 1'b0;

    if (start) begin
      // opcode byte
      in_instr_nxt = 1'b1;
      opcode_nxt   = s1_byte_r;
      ext_nxt      = 8'd0;
      count_nxt    = len_t'(1);
      ovf_nxt      = 1'b0;
      acc_nxt      = 32'd0;
      idx_nxt      = 3'd0;
      targets_nxt  = 33'd0;
      step_nxt     = step_for_opcode(s1_byte_r);
      raw_nxt      = raw_for_opcode(s1_byte_r);
      fire         = (step_nxt == STEP_NONE);
    end else begin
      // length counter saturates
      if (count_r == LEN_MAX) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + len_t'(1);
      end

      case (step_r)
        STEP_RAW: begin
          raw_nxt = raw_dec;
          fire    = (raw_dec == 4'd0);
        end
        STEP_SUB: begin
          ext_nxt  = s1_byte_r;
          step_nxt = step_for_sub(s1_byte_r);
          fire     = (step_nxt == STEP_NONE);
        end
        STEP_LEB_LAST, STEP_LEB_TWO, STEP_ALIGN, STEP_COUNT, STEP_TARGETS: begin
          if (s1_byte_r[7]) begin
            acc_nxt = acc_new;
            idx_nxt = idx_new;
          end else begin
            // leb ends here
            acc_nxt = 32'd0;
            idx_nxt = 3'd0;
            case (step_r)
              STEP_LEB_TWO: step_nxt = STEP_LEB_LAST;
              STEP_ALIGN:   step_nxt = acc_new[6] ? STEP_LEB_TWO : STEP_LEB_LAST;
              STEP_COUNT: begin
                targets_nxt = {1'b0, acc_new} + 33'd1;
                step_nxt    = STEP_TARGETS;
              end
              STEP_TARGETS: begin
                targets_nxt = targets_dec;
                fire        = (targets_dec == 33'd0);
              end
              default:      fire = 1'b1;
            endcase
          end
        end
        default: fire = 1'b1;
      endcase
    end

    // instruction ends: clear field state
    if (fire) begin
      in_instr_nxt = 1'b0;
      step_nxt     = STEP_NONE;
      acc_nxt      = 32'd0;
      idx_nxt      = 3'd0;
      raw_nxt      = 4'd0;
      targets_nxt  = 33'd0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r    <= in_tdata;
      s1_restart_r <= in_tuser;
    end
  end

  // decode state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_instr_r <= 1'b0;
      opcode_r   <= 8'd0;
      ext_r      <= 8'd0;
      step_r     <= STEP_NONE;
      acc_r      <= 32'd0;
      idx_r      <= 3'd0;
      raw_r      <= 4'd0;
      targets_r  <= 33'd0;
      count_r    <= '0;
      ovf_r      <= 1'b0;
    end else if (advance) begin
      in_instr_r <= in_instr_nxt;
      opcode_r   <= opcode_nxt;
      ext_r      <= ext_nxt;
      step_r     <= step_nxt;
      acc_r      <= acc_nxt;
      idx_r      <= idx_nxt;
      raw_r      <= raw_nxt;
      targets_r  <= targets_nxt;
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire) begin
      out_opcode_r <= opcode_nxt;
      out_ext_r    <= ext_nxt;
      out_length_r <= count_nxt;
      out_sat_r    <= ovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_length_r, out_ext_r, out_opcode_r};
  assign out_tuser  = out_sat_r;

  // checks
  `WIBF_ASSERT_IMPL(a_idle_no_step, clk, rst_n, !in_instr_r, step_r == STEP_NONE)
  `WIBF_ASSERT_IMPL(a_raw_nonzero, clk, rst_n, step_r == STEP_RAW, raw_r != 4'd0)
  `WIBF_ASSERT_IMPL(a_idx_bound, clk, rst_n, 1'b1, idx_r <= LEB_MAX_BYTES)
  `WIBF_ASSERT_IMPL(a_sat_len_max, clk, rst_n, out_valid_r && out_sat_r, out_length_r == LEN_MAX)
  `WIBF_ASSERT_NEXT(a_result_ends, clk, rst_n, advance && fire, !in_instr_r)

endmodule
